[src/gbr_pkg.sv]
package gbr_pkg;

  // font geometry
  localparam int GLYPH_COUNT     = 256;
  localparam int MAX_ROWS        = 8;
  localparam int BASELINE_OFFSET = 9;
  localparam int GLYPH_W         = $clog2(GLYPH_COUNT);
  localparam int ROW_W           = $clog2(MAX_ROWS);
  localparam int FONT_DEPTH      = GLYPH_COUNT * MAX_ROWS;
  localparam int FONT_AW         = GLYPH_W + ROW_W;

  // coordinate widths
  localparam int COORD_W = 12;
  localparam int PIX_W   = 13;
  localparam int CALC_W  = 14;

  // config register map (word index)
  localparam int APB_AW = 5;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd0;
  localparam logic [2:0] REG_SCALE        = 3'd1;
  localparam logic [2:0] REG_CLIP_ENABLE  = 3'd2;
  localparam logic [2:0] REG_CLIP_LEFT    = 3'd3;
  localparam logic [2:0] REG_CLIP_TOP     = 3'd4;
  localparam logic [2:0] REG_CLIP_WIDTH   = 3'd5;
  localparam logic [2:0] REG_CLIP_HEIGHT  = 3'd6;

  // reset values
  localparam logic [3:0]  RST_GLYPH_HEIGHT = 4'd8;
  localparam logic [3:0]  RST_SCALE        = 4'd1;
  localparam logic [11:0] RST_CLIP_WIDTH   = 12'd319;
  localparam logic [11:0] RST_CLIP_HEIGHT  = 12'd239;

  typedef enum logic [1:0] {
    FUNC_WRITE_ROW   = 2'd0,
    FUNC_WRITE_WIDTH = 2'd1,
    FUNC_DRAW        = 2'd2,
    FUNC_UNUSED      = 2'd3
  } func_e;

  typedef struct packed {
    logic [3:0]                glyph_height;
    logic [3:0]                scale;
    logic                      clip_enable;
    logic signed [COORD_W-1:0] clip_left;
    logic signed [COORD_W-1:0] clip_top;
    logic [COORD_W-1:0]        clip_width;
    logic [COORD_W-1:0]        clip_height;
  } cfg_t;

  typedef struct packed {
    logic               row_we;
    logic               width_we;
    logic [GLYPH_W-1:0] wr_glyph;
    logic [ROW_W-1:0]   wr_row;
    logic [7:0]         row_data;
    logic [3:0]         width_data;
    logic               rd_en;
    logic [GLYPH_W-1:0] rd_glyph;
    logic [ROW_W-1:0]   rd_row;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] row_data;
    logic [3:0] width_data;
  } mem_rsp_t;

endpackage

[src/glyph_bitmap_rasterizer_unit.sv]
// a load beat is taken whenever the block is idle; a draw fetches the font width and row
// zero when accepted, runs a setup step, scans one font bit per cycle while the output side
// does not stall it (height times width bits, at most 64), then waits in a final step for
// output ready; a new item is accepted only once the draw is done, and the scan reads one font
// row at a time through the single row read port of the font memory
// reset: control and config registers take their reset values at once; font memory is not cleared
module glyph_bitmap_rasterizer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gbr_pkg::APB_AW-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // item channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [7:0]                         char_code_i,
  input  logic [2:0]                         row_index_i,
  input  logic [7:0]                         row_bits_i,
  input  logic [3:0]                         width_value_i,
  input  logic signed [gbr_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [gbr_pkg::COORD_W-1:0] origin_y_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               pixel_valid_o,
  output logic signed [gbr_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [gbr_pkg::PIX_W-1:0]   pixel_y_o,
  output logic signed [gbr_pkg::PIX_W-1:0]   next_x_o,
  output logic                               last_o
);
  import gbr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  logic     cfg_we;
  logic [2:0] reg_idx;

  // no wait states on the config port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register write decode, unmapped words are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        REG_GLYPH_HEIGHT: cfg_d.glyph_height = pwdata[3:0];
        REG_SCALE:        cfg_d.scale        = pwdata[3:0];
        REG_CLIP_ENABLE:  cfg_d.clip_enable  = pwdata[0];
        REG_CLIP_LEFT:    cfg_d.clip_left    = pwdata[COORD_W-1:0];
        REG_CLIP_TOP:     cfg_d.clip_top     = pwdata[COORD_W-1:0];
        REG_CLIP_WIDTH:   cfg_d.clip_width   = pwdata[COORD_W-1:0];
        REG_CLIP_HEIGHT:  cfg_d.clip_height  = pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_height <= RST_GLYPH_HEIGHT;
      cfg_q.scale        <= RST_SCALE;
      cfg_q.clip_enable  <= 1'b0;
      cfg_q.clip_left    <= '0;
      cfg_q.clip_top     <= '0;
      cfg_q.clip_width   <= RST_CLIP_WIDTH;
      cfg_q.clip_height  <= RST_CLIP_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // readback, signed fields come back sign extended
  always_comb begin
    case (reg_idx)
      REG_GLYPH_HEIGHT: prdata = {28'd0, cfg_q.glyph_height};
      REG_SCALE:        prdata = {28'd0, cfg_q.scale};
      REG_CLIP_ENABLE:  prdata = {31'd0, cfg_q.clip_enable};
      REG_CLIP_LEFT:    prdata = {{(32-COORD_W){cfg_q.clip_left[COORD_W-1]}}, cfg_q.clip_left};
      REG_CLIP_TOP:     prdata = {{(32-COORD_W){cfg_q.clip_top[COORD_W-1]}}, cfg_q.clip_top};
      REG_CLIP_WIDTH:   prdata = {{(32-COORD_W){1'b0}}, cfg_q.clip_width};
      REG_CLIP_HEIGHT:  prdata = {{(32-COORD_W){1'b0}}, cfg_q.clip_height};
      default:          prdata = '0;
    endcase
  end

  // font rows and glyph widths, registered read
  gbr_font_mem u_font_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // item decode, row/bit walk and result register
  gbr_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .row_index_i   (row_index_i),
    .row_bits_i    (row_bits_i),
    .width_value_i (width_value_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .mem_req_o     (mem_req),
    .mem_rsp_i     (mem_rsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .next_x_o      (next_x_o),
    .last_o        (last_o)
  );

endmodule

[src/gbr_font_mem.sv]
module gbr_font_mem (
  input  logic              clk_i,
  input  gbr_pkg::mem_req_t req_i,
  output gbr_pkg::mem_rsp_t rsp_o
);
  import gbr_pkg::*;

  logic [7:0] font_rows    [FONT_DEPTH];
  logic [3:0] glyph_widths [GLYPH_COUNT];

  logic [7:0] row_rdata_q;
  logic [3:0] width_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.row_we) begin
      font_rows[{req_i.wr_glyph, req_i.wr_row}] <= req_i.row_data;
    end
    if (req_i.width_we) begin
      glyph_widths[req_i.wr_glyph] <= req_i.width_data;
    end
  end

  // read data stays put until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      row_rdata_q   <= font_rows[{req_i.rd_glyph, req_i.rd_row}];
      width_rdata_q <= glyph_widths[req_i.rd_glyph];
    end
  end

  assign rsp_o.row_data   = row_rdata_q;
  assign rsp_o.width_data = width_rdata_q;

endmodule

[src/gbr_walk.sv]
module gbr_walk (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbr_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [7:0]                          char_code_i,
  input  logic [2:0]                          row_index_i,
  input  logic [7:0]                          row_bits_i,
  input  logic [3:0]                          width_value_i,
  input  logic signed [gbr_pkg::COORD_W-1:0]  origin_x_i,
  input  logic signed [gbr_pkg::COORD_W-1:0]  origin_y_i,
  output gbr_pkg::mem_req_t                   mem_req_o,
  input  gbr_pkg::mem_rsp_t                   mem_rsp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                pixel_valid_o,
  output logic signed [gbr_pkg::PIX_W-1:0]    pixel_x_o,
  output logic signed [gbr_pkg::PIX_W-1:0]    pixel_y_o,
  output logic signed [gbr_pkg::PIX_W-1:0]    next_x_o,
  output logic                                last_o
);
  import gbr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [GLYPH_W-1:0]       glyph_q, glyph_d;
  logic signed [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [3:0]               width_q, width_d;
  logic [3:0]               height_q, height_d;
  logic signed [PIX_W-1:0]  nx_q, nx_d;
  logic signed [CALC_W-1:0] x_q, x_d, y_q, y_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic [2:0]               bit_q, bit_d;
  logic                     have_q, have_d;
  logic signed [PIX_W-1:0]  lx_q, lx_d, ly_q, ly_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_pv_q, out_pv_d, out_last_q, out_last_d;
  logic signed [PIX_W-1:0]  out_px_q, out_px_d, out_py_q, out_py_d, out_nx_q, out_nx_d;

  logic                     accept, out_free, out_load;
  logic [3:0]               width_clamp, height_clamp;
  logic [7:0]               adv_prod;
  logic signed [CALC_W-1:0] ox_ext, oy_ext, sc_ext, right_s, bottom_s, left_s, top_s;
  logic                     bit_set, in_window, found, stall, last_bit, last_row;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);

  assign ox_ext   = {{(CALC_W-COORD_W){ox_q[COORD_W-1]}}, ox_q};
  assign oy_ext   = {{(CALC_W-COORD_W){oy_q[COORD_W-1]}}, oy_q};
  assign sc_ext   = {{(CALC_W-4){1'b0}}, cfg_i.scale};
  assign left_s   = {{(CALC_W-COORD_W){cfg_i.clip_left[COORD_W-1]}}, cfg_i.clip_left};
  assign top_s    = {{(CALC_W-COORD_W){cfg_i.clip_top[COORD_W-1]}}, cfg_i.clip_top};
  assign right_s  = left_s + $signed({{(CALC_W-COORD_W){1'b0}}, cfg_i.clip_width});
  assign bottom_s = top_s + $signed({{(CALC_W-COORD_W){1'b0}}, cfg_i.clip_height});

  assign width_clamp  = (mem_rsp_i.width_data > 4'd8) ? 4'd8 : mem_rsp_i.width_data;
  assign height_clamp = (cfg_i.glyph_height > 4'(MAX_ROWS)) ? 4'(MAX_ROWS)
                                                            : cfg_i.glyph_height;
  assign adv_prod     = 8'(width_clamp) * 8'(cfg_i.scale);

  assign bit_set   = mem_rsp_i.row_data[bit_q];
  assign in_window = (x_q >= left_s) && (x_q <= right_s) &&
                     (y_q >= top_s) && (y_q <= bottom_s);
  assign found     = bit_set && (!cfg_i.clip_enable || in_window);
  assign stall     = found && have_q && !out_free;
  assign last_bit  = ({1'b0, bit_q} == (4'd8 - width_q));
  assign last_row  = ((4'(row_q) + 4'd1) == height_q);

  always_comb begin
    state_d  = state_q;
    glyph_d  = glyph_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    width_d  = width_q;
    height_d = height_q;
    nx_d     = nx_q;
    x_d      = x_q;
    y_d      = y_q;
    row_d    = row_q;
    bit_d    = bit_q;
    have_d   = have_q;
    lx_d     = lx_q;
    ly_d     = ly_q;

    out_load   = 1'b0;
    out_pv_d   = out_pv_q;
    out_px_d   = out_px_q;
    out_py_d   = out_py_q;
    out_nx_d   = out_nx_q;
    out_last_d = out_last_q;

    mem_req_o            = '0;
    mem_req_o.wr_glyph   = char_code_i[GLYPH_W-1:0];
    mem_req_o.wr_row     = row_index_i[ROW_W-1:0];
    mem_req_o.row_data   = row_bits_i;
    mem_req_o.width_data = width_value_i;
    mem_req_o.rd_glyph   = glyph_q;
    mem_req_o.rd_row     = row_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_WRITE_ROW: begin
              mem_req_o.row_we = (4'(row_index_i) < 4'(MAX_ROWS));
            end
            FUNC_WRITE_WIDTH: begin
              mem_req_o.width_we = 1'b1;
            end
            FUNC_DRAW: begin
              // fetch width and row zero together
              mem_req_o.rd_en    = 1'b1;
              mem_req_o.rd_glyph = char_code_i[GLYPH_W-1:0];
              mem_req_o.rd_row   = '0;
              glyph_d = char_code_i[GLYPH_W-1:0];
              ox_d    = origin_x_i;
              oy_d    = origin_y_i;
              state_d = ST_PREP;
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        width_d  = width_clamp;
        height_d = height_clamp;
        nx_d     = PIX_W'(ox_ext) + PIX_W'(adv_prod) + PIX_W'(cfg_i.clip_enable);
        x_d      = ox_ext;
        y_d      = oy_ext + CALC_W'(BASELINE_OFFSET) - CALC_W'(height_clamp);
        row_d    = '0;
        bit_d    = 3'd7;
        have_d   = 1'b0;
        if ((width_clamp == 4'd0) || (height_clamp == 4'd0)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (found) begin
            if (have_q) begin
              out_load   = 1'b1;
              out_pv_d   = 1'b1;
              out_px_d   = lx_q;
              out_py_d   = ly_q;
              out_nx_d   = nx_q;
              out_last_d = 1'b0;
            end
            have_d = 1'b1;
            lx_d   = x_q[PIX_W-1:0];
            ly_d   = y_q[PIX_W-1:0];
          end
          x_d   = x_q + sc_ext;
          bit_d = bit_q - 3'd1;
          if (last_bit) begin
            x_d   = ox_ext;
            y_d   = y_q + sc_ext;
            bit_d = 3'd7;
            row_d = row_q + ROW_W'(1);
            if (last_row) begin
              row_d   = '0;
              state_d = ST_DONE;
            end else begin
              mem_req_o.rd_en  = 1'b1;
              mem_req_o.rd_row = row_q + ROW_W'(1);
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_pv_d   = have_q;
          out_px_d   = have_q ? lx_q : '0;
          out_py_d   = have_q ? ly_q : '0;
          out_nx_d   = nx_q;
          out_last_d = 1'b1;
          have_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      bit_q       <= 3'd7;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      bit_q       <= bit_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q    <= glyph_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    width_q    <= width_d;
    height_q   <= height_d;
    nx_q       <= nx_d;
    x_q        <= x_d;
    y_q        <= y_d;
    lx_q       <= lx_d;
    ly_q       <= ly_d;
    out_pv_q   <= out_pv_d;
    out_px_q   <= out_px_d;
    out_py_q   <= out_py_d;
    out_nx_q   <= out_nx_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_valid_o = out_pv_q;
  assign pixel_x_o     = out_px_q;
  assign pixel_y_o     = out_py_q;
  assign next_x_o      = out_nx_q;
  assign last_o        = out_last_q;

endmodule

[sim/tb.sv]
module tb;
  import gbr_pkg::*;

  // run control
  localparam int IDLE_LIMIT  = 3000;  // cycles with no beat on either channel
  localparam int SETTLE_CYC  = 80;    // wait after a drained queue for the last draw to finish
  localparam int HOLD_CYC    = 400;   // one long hold-off on the result side
  localparam int HOLD_AT     = 70;    // result beats seen before the hold-off starts
  localparam int MAX_REPORTS = 10;

  // row bytes of the sparse test glyph, row 0 in the top byte
  localparam logic [63:0] SPARSE_GLYPH = 64'h0080_01A5_5A00_FF81;

  typedef struct {
    func_e                     func;
    logic [7:0]                char_code;
    logic [ROW_W-1:0]          row_index;
    logic [7:0]                row_bits;
    logic [3:0]                width_value;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } glyph_cmd_t;

  typedef struct {
    logic                    pixel_valid;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic signed [PIX_W-1:0] next_x;
    logic                    last;
  } pixel_beat_t;

  // clock, reset and block pins
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [APB_AW-1:0]         paddr         = '0;
  logic [31:0]               pwdata        = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                func_i        = '0;
  logic [7:0]                char_code_i   = '0;
  logic [2:0]                row_index_i   = '0;
  logic [7:0]                row_bits_i    = '0;
  logic [3:0]                width_value_i = '0;
  logic signed [COORD_W-1:0] origin_x_i    = '0;
  logic signed [COORD_W-1:0] origin_y_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic                      pixel_valid_o;
  logic signed [PIX_W-1:0]   pixel_x_o;
  logic signed [PIX_W-1:0]   pixel_y_o;
  logic signed [PIX_W-1:0]   next_x_o;
  logic                      last_o;

  // stimulus side bookkeeping
  glyph_cmd_t  cmd_pending [$];          // commands not yet offered
  glyph_cmd_t  drv_cmd;                  // command currently on the input pins
  bit [7:0]    rows_set  [GLYPH_COUNT];  // rows written so far, per glyph
  bit          width_set [GLYPH_COUNT];
  bit          can_draw  [GLYPH_COUNT];
  logic [7:0]  drawable  [$];            // glyphs fully loaded, safe to draw

  // predictor state: the shadow font and owed beats update at each accepted command
  cfg_t        cfg_sh;
  logic [7:0]  font_shadow  [FONT_DEPTH];
  logic [3:0]  width_shadow [GLYPH_COUNT];
  pixel_beat_t pixels_due [$];           // result beats still owed by the block

  // handshake tracking
  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int          send_gap    = 0;
  bit          send_burst  = 1'b0;
  int          recv_gap    = 0;
  bit          recv_burst  = 1'b0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          beats_seen  = 0;
  int          idle_cycles = 0;
  int          mismatches  = 0;

  glyph_bitmap_rasterizer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .row_index_i   (row_index_i),
    .row_bits_i    (row_bits_i),
    .width_value_i (width_value_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .next_x_o      (next_x_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // expected beat, coordinates wrapped to the output width
  function automatic pixel_beat_t make_beat(input logic pv, input int px, input int py,
                                            input int nx, input logic lst);
    pixel_beat_t pb;
    pb.pixel_valid = pv;
    pb.pixel_x     = px[PIX_W-1:0];
    pb.pixel_y     = py[PIX_W-1:0];
    pb.next_x      = nx[PIX_W-1:0];
    pb.last        = lst;
    return pb;
  endfunction

  // font loads update the shadow font, draws walk the glyph and queue its pixel squares
  function automatic void rasterize_cmd(input glyph_cmd_t c);
    int         wid, hgt, sc, ox, oy, nx;
    int         cl, ct, cw, ch, rgt, bot;
    int         x, y, lx, ly;
    bit         seen, keep;
    logic [7:0] bits;
    case (c.func)
      FUNC_WRITE_ROW: font_shadow[{c.char_code, c.row_index}] = c.row_bits;
      FUNC_WRITE_WIDTH: width_shadow[c.char_code] = c.width_value;
      FUNC_DRAW: begin
        wid = int'(width_shadow[c.char_code]);
        if (wid > 8) wid = 8;                 // wide glyphs clamp to one byte
        hgt = int'(cfg_sh.glyph_height);
        if (hgt > MAX_ROWS) hgt = MAX_ROWS;   // tall setting clamps to the font depth
        sc  = int'(cfg_sh.scale);
        ox  = int'(c.origin_x);
        oy  = int'(c.origin_y);
        nx  = ox + wid * sc + (cfg_sh.clip_enable ? 1 : 0);
        cl  = int'($signed(cfg_sh.clip_left));
        ct  = int'($signed(cfg_sh.clip_top));
        cw  = int'(cfg_sh.clip_width);
        ch  = int'(cfg_sh.clip_height);
        rgt = cl + cw;
        bot = ct + ch;
        seen = 1'b0;
        lx   = 0;
        ly   = 0;
        for (int b = 0; b < hgt; b++) begin
          bits = font_shadow[{c.char_code, 3'(b)}];
          y    = oy + b * sc + BASELINE_OFFSET - hgt;
          x    = ox;
          for (int k = 0; k < wid; k++) begin
            if (bits[7-k]) begin
              keep = !cfg_sh.clip_enable ||
                     (x >= cl && x <= rgt && y >= ct && y <= bot);
              if (keep) begin
                // hold each square back one step so the final one can carry last
                if (seen) pixels_due.push_back(make_beat(1'b1, lx, ly, nx, 1'b0));
                lx   = x;
                ly   = y;
                seen = 1'b1;
              end
            end
            x = x + sc;
          end
        end
        if (seen) pixels_due.push_back(make_beat(1'b1, lx, ly, nx, 1'b1));
        else pixels_due.push_back(make_beat(1'b0, 0, 0, nx, 1'b1));  // advance only
      end
      default: ;  // unused code: no effect
    endcase
  endfunction

  // queue one command and track which glyphs are fully loaded
  function automatic void push_cmd(input func_e f, input logic [7:0] code,
                                   input logic [2:0] row, input logic [7:0] bits,
                                   input logic [3:0] wv, input logic [11:0] ox,
                                   input logic [11:0] oy);
    glyph_cmd_t c;
    c.func        = f;
    c.char_code   = code;
    c.row_index   = row;
    c.row_bits    = bits;
    c.width_value = wv;
    c.origin_x    = ox;
    c.origin_y    = oy;
    cmd_pending.push_back(c);
    if (f == FUNC_WRITE_ROW) rows_set[code][row] = 1'b1;
    if (f == FUNC_WRITE_WIDTH) width_set[code] = 1'b1;
    if (rows_set[code] == 8'hFF && width_set[code] && !can_draw[code]) begin
      can_draw[code] = 1'b1;
      drawable.push_back(code);
    end
  endfunction

  // origin coordinate: mostly near the clip window edge, sometimes anywhere or at an extreme
  function automatic logic [11:0] rand_coord(input int anchor);
    int c;
    case ($urandom_range(0, 9))
      0: c = -2048;
      1: c = 2047;
      2, 3: c = int'($urandom_range(0, 4095)) - 2048;
      default: c = anchor + int'($urandom_range(0, 80)) - 40;
    endcase
    if (c < -2048) c = -2048;
    if (c > 2047) c = 2047;
    return c[11:0];
  endfunction

  // random traffic: whole glyph loads, stray row and width rewrites, unused codes and
  // mostly draws of loaded glyphs
  task automatic queue_random(input int count);
    int         made, pick;
    logic [7:0] code;
    logic [3:0] wv;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (drawable.size() == 0 || pick < 15) begin
        code = 8'($urandom);
        for (int r = 0; r < MAX_ROWS; r++) begin
          case ($urandom_range(0, 9))
            0: push_cmd(FUNC_WRITE_ROW, code, 3'(r), 8'h00, 4'($urandom), 12'($urandom),
                        12'($urandom));
            1: push_cmd(FUNC_WRITE_ROW, code, 3'(r), 8'hFF, 4'($urandom), 12'($urandom),
                        12'($urandom));
            default: push_cmd(FUNC_WRITE_ROW, code, 3'(r), 8'($urandom), 4'($urandom),
                              12'($urandom), 12'($urandom));
          endcase
        end
        case ($urandom_range(0, 9))
          0: wv = 4'd0;
          1: wv = 4'($urandom_range(9, 15));
          default: wv = 4'($urandom_range(1, 8));
        endcase
        push_cmd(FUNC_WRITE_WIDTH, code, 3'($urandom), 8'($urandom), wv, 12'($urandom),
                 12'($urandom));
        made += MAX_ROWS + 1;
      end else if (pick < 25) begin
        push_cmd(FUNC_WRITE_ROW, 8'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
                 12'($urandom), 12'($urandom));
        made++;
      end else if (pick < 33) begin
        push_cmd(FUNC_WRITE_WIDTH, 8'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
                 12'($urandom), 12'($urandom));
        made++;
      end else if (pick < 37) begin
        // ignored by the block, not counted
        push_cmd(FUNC_UNUSED, 8'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
                 12'($urandom), 12'($urandom));
      end else begin
        code = drawable[$urandom_range(0, drawable.size() - 1)];
        push_cmd(FUNC_DRAW, code, 3'($urandom), 8'($urandom), 4'($urandom),
                 rand_coord(int'($signed(cfg_sh.clip_left))),
                 rand_coord(int'($signed(cfg_sh.clip_top))));
        made++;
      end
    end
  endtask

  // apb write: setup cycle, then access until pready
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write every register, then mirror the setting in the predictor
  task automatic apply_setting(input int hgt, input int scl, input int ce, input int cl,
                               input int ct, input int cw, input int ch);
    cfg_write(REG_GLYPH_HEIGHT, 32'(hgt) & 32'hF);
    cfg_write(REG_SCALE,        32'(scl) & 32'hF);
    cfg_write(REG_CLIP_ENABLE,  32'(ce)  & 32'h1);
    cfg_write(REG_CLIP_LEFT,    32'(cl)  & 32'hFFF);
    cfg_write(REG_CLIP_TOP,     32'(ct)  & 32'hFFF);
    cfg_write(REG_CLIP_WIDTH,   32'(cw)  & 32'hFFF);
    cfg_write(REG_CLIP_HEIGHT,  32'(ch)  & 32'hFFF);
    cfg_sh.glyph_height = 4'(hgt);
    cfg_sh.scale        = 4'(scl);
    cfg_sh.clip_enable  = 1'(ce);
    cfg_sh.clip_left    = 12'(cl);
    cfg_sh.clip_top     = 12'(ct);
    cfg_sh.clip_width   = 12'(cw);
    cfg_sh.clip_height  = 12'(ch);
  endtask

  // block idle: nothing queued, nothing on the pins, no beat owed, then the draw latency
  task automatic wait_drained();
    while (cmd_pending.size() != 0 || in_valid_i || pixels_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic void flag_mismatch(input string what, input pixel_beat_t want,
                                        input pixel_beat_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch, %s: want v=%0b x=%0d y=%0d nx=%0d last=%0b", what,
               want.pixel_valid, want.pixel_x, want.pixel_y, want.next_x, want.last,
               " | got v=%0b x=%0d y=%0d nx=%0d last=%0b",
               got.pixel_valid, got.pixel_x, got.pixel_y, got.next_x, got.last);
  endfunction

  // input driver: one command per beat, random gap after each, bursts with no gap
  always @(negedge clk_i) begin : drive_proc
    logic v;
    v = in_valid_i;
    if (rst_ni) begin
      if (in_taken) v = 1'b0;  // last beat went through
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_pending.size() != 0) begin
          drv_cmd = cmd_pending.pop_front();
          v = 1'b1;
          if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 19);
          func_i        <= drv_cmd.func;
          char_code_i   <= drv_cmd.char_code;
          row_index_i   <= drv_cmd.row_index;
          row_bits_i    <= drv_cmd.row_bits;
          width_value_i <= drv_cmd.width_value;
          origin_x_i    <= drv_cmd.origin_x;
          origin_y_i    <= drv_cmd.origin_y;
        end
      end
    end
    in_valid_i <= v;
  end

  // result side ready: random wait per beat, plus one long hold-off to back up the input
  always @(negedge clk_i) begin : accept_proc
    logic r;
    if (out_taken) begin
      if ($urandom_range(0, 7) == 0) recv_burst = !recv_burst;
      recv_gap = recv_burst ? 0 : $urandom_range(0, 19);
    end
    if (!hold_done && beats_seen >= HOLD_AT) begin
      hold_left = HOLD_CYC;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      r = 1'b0;
    end else begin
      r = rst_ni;
    end
    out_ready_i <= r;
  end

  // monitor: check result beats in order, feed accepted commands to the predictor
  always @(posedge clk_i) begin : watch_proc
    pixel_beat_t want, got;
    if (rst_ni) begin
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
      if (out_valid_o && out_ready_i) begin
        got.pixel_valid = pixel_valid_o;
        got.pixel_x     = pixel_x_o;
        got.pixel_y     = pixel_y_o;
        got.next_x      = next_x_o;
        got.last        = last_o;
        beats_seen++;
        if (pixels_due.size() == 0) begin
          flag_mismatch("no beat owed", got, got);
        end else begin
          want = pixels_due.pop_front();
          if (want.pixel_valid !== got.pixel_valid || want.pixel_x !== got.pixel_x ||
              want.pixel_y !== got.pixel_y || want.next_x !== got.next_x ||
              want.last !== got.last)
            flag_mismatch("field differs", want, got);
        end
      end
      if (in_valid_i && in_ready_o) rasterize_cmd(drv_cmd);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: no beat on either channel for too long
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin
    cfg_sh.glyph_height = RST_GLYPH_HEIGHT;
    cfg_sh.scale        = RST_SCALE;
    cfg_sh.clip_enable  = 1'b0;
    cfg_sh.clip_left    = '0;
    cfg_sh.clip_top     = '0;
    cfg_sh.clip_width   = RST_CLIP_WIDTH;
    cfg_sh.clip_height  = RST_CLIP_HEIGHT;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset setting
    // solid glyph at the top code, width above eight
    for (int r = 0; r < MAX_ROWS; r++)
      push_cmd(FUNC_WRITE_ROW, 8'hFF, 3'(r), 8'hFF, 4'($urandom), 12'($urandom),
               12'($urandom));
    push_cmd(FUNC_WRITE_WIDTH, 8'hFF, 3'($urandom), 8'($urandom), 4'hF, 12'($urandom),
             12'($urandom));
    // sparse glyph at code zero, first with zero width
    for (int r = 0; r < MAX_ROWS; r++)
      push_cmd(FUNC_WRITE_ROW, 8'h00, 3'(r), SPARSE_GLYPH[63-8*r -: 8], 4'($urandom),
               12'($urandom), 12'($urandom));
    push_cmd(FUNC_WRITE_WIDTH, 8'h00, 3'($urandom), 8'($urandom), 4'd0, 12'($urandom),
             12'($urandom));
    // zero width: a single non-pixel beat with the advance
    push_cmd(FUNC_DRAW, 8'h00, 3'($urandom), 8'($urandom), 4'($urandom), 12'h800, 12'h800);
    push_cmd(FUNC_WRITE_WIDTH, 8'h00, 3'($urandom), 8'($urandom), 4'd8, 12'($urandom),
             12'($urandom));
    // full 64 squares at the far corner
    push_cmd(FUNC_DRAW, 8'hFF, 3'($urandom), 8'($urandom), 4'($urandom), 12'h7FF, 12'h7FF);
    push_cmd(FUNC_DRAW, 8'h00, 3'($urandom), 8'($urandom), 4'($urandom), 12'h800, 12'h7FF);
    push_cmd(FUNC_UNUSED, 8'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
             12'($urandom), 12'($urandom));
    push_cmd(FUNC_DRAW, 8'h00, 3'($urandom), 8'($urandom), 4'($urandom), 12'h000, 12'h000);
    queue_random(25);
    wait_drained();

    // big scale, clipping on with the widest window
    apply_setting(8, 8, 1, -2048, -2048, 4095, 4095);
    queue_random(27);
    wait_drained();

    // one-row glyphs, window shrunk to a single point
    apply_setting(1, 1, 1, 0, 0, 0, 0);
    queue_random(27);
    wait_drained();

    // zero height: advance only
    apply_setting(0, 5, 0, 100, -50, 200, 100);
    queue_random(27);
    wait_drained();

    // height above the font depth, zero scale collapses squares onto a single point
    apply_setting(15, 0, 1, -100, -100, 400, 400);
    queue_random(27);
    wait_drained();

    // largest scale, window values at the top of their range
    apply_setting(8, 15, 0, 2047, 2047, 4095, 4095);
    queue_random(27);
    wait_drained();

    // random setting in the normal range
    apply_setting($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 1),
                  int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                  $urandom_range(0, 300), $urandom_range(0, 300));
    queue_random(27);
    wait_drained();

    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
